// ----- rtl/tpq_pkg.sv -----
`default_nettype none

package tpq_pkg;

  localparam int unsigned POS_W     = 3;
  localparam int unsigned POS_MAX   = 5;
  localparam int unsigned HOLDOFF_W = 8;

  localparam logic [HOLDOFF_W-1:0] HOLDOFF_RESET = 8'd250;

  // Window entries start at the bottom end of the pot travel.
  localparam int unsigned WINDOW_RESET_SAMPLE = 768;

  // The curve 768->0, 682->30, 352->90, 304->120, then /20 and clamp 0..5,
  // is a falling step function of the mean. Position is at least k+1
  // exactly when the mean is at or below MEAN_LIMIT[k].
  localparam int unsigned POS_STEPS = 5;
  localparam int unsigned MEAN_LIMIT [POS_STEPS] = '{710, 627, 517, 407, 336};

  typedef logic [POS_W-1:0] pos_t;

  typedef struct packed {
    pos_t position;
    logic changed;
    logic sample_taken;
  } tpq_result_t;

endpackage

`default_nettype wire

// ----- rtl/tpq_quant.sv -----
`default_nettype none

// Window sum -> position. Compares the sum against limits scaled by the
// window depth, so the mean is never divided out.
module tpq_quant #(
  parameter int WINDOW_DEPTH = 4,
  parameter int SUM_W        = 12
) (
  input  logic [SUM_W-1:0] total,
  output tpq_pkg::pos_t    position
);

  always_comb begin
    position = '0;
    for (int k = 0; k < tpq_pkg::POS_STEPS; k++) begin
      if (32'(total) < (tpq_pkg::MEAN_LIMIT[k] + 1) * unsigned'(WINDOW_DEPTH)) begin
        position = position + tpq_pkg::pos_t'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/tpq_track.sv -----
`default_nettype none

// Sample window, running sum, hold-off counter and position history.
module tpq_track #(
  parameter int WINDOW_DEPTH = 4,
  parameter int SAMPLE_BITS  = 10
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               step,
  input  logic [SAMPLE_BITS-1:0]             sample,
  input  logic [tpq_pkg::HOLDOFF_W-1:0]      holdoff_ticks,
  output tpq_pkg::tpq_result_t               result
);

  localparam int SUM_W = SAMPLE_BITS + $clog2(WINDOW_DEPTH);
  localparam logic [SAMPLE_BITS-1:0] RESET_SAMPLE =
    SAMPLE_BITS'(tpq_pkg::WINDOW_RESET_SAMPLE);
  localparam logic [SUM_W-1:0] RESET_TOTAL =
    SUM_W'(WINDOW_DEPTH * int'(RESET_SAMPLE));

  logic [SAMPLE_BITS-1:0]          window [WINDOW_DEPTH];
  logic [SUM_W-1:0]                total;
  logic [SUM_W-1:0]                total_next;
  logic [tpq_pkg::HOLDOFF_W-1:0]   holdoff_count;
  logic [tpq_pkg::HOLDOFF_W-1:0]   holdoff_count_next;
  tpq_pkg::pos_t                   cur_position;
  tpq_pkg::pos_t                   prev_position;
  tpq_pkg::pos_t                   new_position;
  logic                            holding;

  // window[0] is the oldest entry; it drops out as the new sample comes in
  assign total_next = total - SUM_W'(window[0]) + SUM_W'(sample);

  tpq_quant #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .SUM_W        (SUM_W)
  ) u_quant (
    .total    (total_next),
    .position (new_position)
  );

  assign holding            = (holdoff_count != '0);
  assign holdoff_count_next = holding ? holdoff_count - 1'b1 : holdoff_ticks;

  always_comb begin
    result.sample_taken = !holding;
    result.position     = holding ? cur_position : new_position;
    result.changed      = (holdoff_count_next == '0) &&
                          (holding ? (cur_position != prev_position)
                                   : (new_position != cur_position));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
        window[i] <= RESET_SAMPLE;
      end
      total         <= RESET_TOTAL;
      holdoff_count <= '0;
      cur_position  <= '0;
      prev_position <= '0;
    end else if (step) begin
      holdoff_count <= holdoff_count_next;
      if (!holding) begin
        for (int i = 0; i < WINDOW_DEPTH - 1; i++) begin
          window[i] <= window[i+1];
        end
        window[WINDOW_DEPTH-1] <= sample;
        total         <= total_next;
        prev_position <= cur_position;
        cur_position  <= new_position;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/throttle_pot_position_quantizer_top.sv -----
`default_nettype none

// Throttle pot position quantizer. Each input transaction carries one
// converter sample and yields exactly one result transaction with the
// coarse throttle position (0..5), a changed flag and a sample_taken flag.
// After every sample that is used, the next holdoff_ticks samples are
// skipped (sample_taken = 0, position repeated). Used samples go through a
// WINDOW_DEPTH-entry moving average and a falling three-segment curve.
// Rate: one transaction per cycle sustained while out_stall is low (input
// register, then result register). The running window sum is updated with
// one add/subtract per used sample, and the curve is a handful of constant
// compares on that sum, so all per-sample work fits between the two
// registers. in_stall only rises when both registers are full and the
// result side is stalling. holdoff_ticks (reset 250) is written through the
// cfg port, which is always ready; write it only while no transaction is in
// flight.
module throttle_pot_position_quantizer_top #(
  parameter int WINDOW_DEPTH = 4,
  parameter int SAMPLE_BITS  = 10
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration write
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tpq_pkg::HOLDOFF_W-1:0] cfg_data,
  // sample input
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [SAMPLE_BITS-1:0]        adc_sample,
  // result output
  output logic                          out_valid,
  input  logic                          out_stall,
  output tpq_pkg::pos_t                 position,
  output logic                          changed,
  output logic                          sample_taken
);

  logic [tpq_pkg::HOLDOFF_W-1:0] holdoff_ticks;
  logic                          in_full;
  logic [SAMPLE_BITS-1:0]        in_sample;
  logic                          accept;
  logic                          advance;
  tpq_pkg::tpq_result_t          res;

  // Config register: always ready.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      holdoff_ticks <= tpq_pkg::HOLDOFF_RESET;
    end else if (cfg_valid && cfg_ready) begin
      holdoff_ticks <= cfg_data;
    end
  end

  // Input register moves into the result register whenever that one is
  // empty or being drained this cycle.
  assign advance  = in_full && (!out_valid || !out_stall);
  assign in_stall = in_full && out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (accept) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_sample <= adc_sample;
    end
  end

  // State and the whole per-sample computation.
  tpq_track #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_track (
    .clk           (clk),
    .rst           (rst),
    .step          (advance),
    .sample        (in_sample),
    .holdoff_ticks (holdoff_ticks),
    .result        (res)
  );

  // Result register. position resets to the tracker's reset position so the
  // register always mirrors the current position.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      position  <= '0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
        position  <= res.position;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      changed      <= res.changed;
      sample_taken <= res.sample_taken;
    end
  end

  // Checks

  // Never load the input register while it still holds an unmoved sample.
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    accept |-> (!in_full || advance))
    else $error("input register overwritten");

  // A skipped sample repeats the last reported position.
  a_hold_repeats: assert property (@(posedge clk) disable iff (rst)
    (advance && !res.sample_taken) |=> (position == $past(position)))
    else $error("position moved during hold-off");

  // With a nonzero hold-off, a used sample cannot report a change yet.
  a_no_change_on_take: assert property (@(posedge clk) disable iff (rst)
    (advance && res.sample_taken && (holdoff_ticks != '0)) |-> !res.changed)
    else $error("changed set while hold-off reloads");

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (32'(position) <= tpq_pkg::POS_MAX))
    else $error("position out of range");

endmodule

`default_nettype wire

// ----- tb/throttle_pot_position_quantizer_top_test.sv -----
`timescale 1ns / 1ps

module throttle_pot_position_quantizer_top_test;

  localparam int WINDOW_DEPTH  = 4;
  localparam int SAMPLE_BITS   = 10;
  localparam int IDLE_PCT      = 35;
  localparam int WATCHDOG_MAX  = 2000;
  // two register stages inside the block, plus margin
  localparam int DRAIN_CYCLES  = 4;
  localparam int TAIL_CYCLES   = 10;

  // curve breakpoints and the final step size
  localparam int PT_MIN        = 768;
  localparam int PT_LOW_SPLIT  = 682;
  localparam int PT_HIGH_SPLIT = 352;
  localparam int PT_MAX        = 304;
  localparam int STEP_DIV      = 20;

  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef logic [tpq_pkg::HOLDOFF_W-1:0] ticks_t;

  // all inputs start at known values
  logic                 clk          = 1'b0;
  logic                 rst          = 1'b1;
  logic                 cfg_valid    = 1'b0;
  logic                 cfg_ready;
  ticks_t               cfg_data     = '0;
  logic                 in_valid     = 1'b0;
  logic                 in_stall;
  sample_t              adc_sample   = '0;
  logic                 out_valid;
  logic                 out_stall    = 1'b0;
  tpq_pkg::pos_t        position;
  logic                 changed;
  logic                 sample_taken;

  throttle_pot_position_quantizer_top #(
    .WINDOW_DEPTH(WINDOW_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) uut (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .adc_sample  (adc_sample),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .position    (position),
    .changed     (changed),
    .sample_taken(sample_taken)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 0;
  end

  // samples waiting to be sent, and results predicted but not yet seen
  sample_t              sample_backlog[$];
  tpq_pkg::tpq_result_t pending_results[$];
  int                   error_count = 0;
  // when set, neither side inserts gaps or stalls
  bit                   steady = 1'b0;

  // ---------------------------------------------------------------------
  // Position predictor: own copy of the averaging window, hold-off counter
  // and position history. holdoff_setting mirrors the cfg register.
  // ---------------------------------------------------------------------
  sample_t              avg_window[WINDOW_DEPTH];
  ticks_t               holdoff_left    = '0;
  ticks_t               holdoff_setting = tpq_pkg::HOLDOFF_RESET;
  tpq_pkg::pos_t        pos_now         = '0;
  tpq_pkg::pos_t        pos_before      = '0;

  initial begin
    for (int i = 0; i < WINDOW_DEPTH; i++) avg_window[i] = sample_t'(PT_MIN);
  end

  // Piecewise-linear falling curve, then /20 and clamp. All divisions are
  // signed int, which truncates toward zero.
  function automatic tpq_pkg::pos_t mean_to_position(int mean);
    int v;
    if (mean > PT_LOW_SPLIT)
      v = (mean - PT_MIN) * 30 / (PT_LOW_SPLIT - PT_MIN);
    else if (mean > PT_HIGH_SPLIT)
      v = (mean - PT_LOW_SPLIT) * 60 / (PT_HIGH_SPLIT - PT_LOW_SPLIT) + 30;
    else
      v = (mean - PT_HIGH_SPLIT) * 30 / (PT_MAX - PT_HIGH_SPLIT) + 90;
    v = v / STEP_DIV;
    if (v < 0) v = 0;
    if (v > tpq_pkg::POS_MAX) v = tpq_pkg::POS_MAX;
    return tpq_pkg::pos_t'(v);
  endfunction

  // Advance the predictor by one sample and return the expected result.
  function automatic tpq_pkg::tpq_result_t predict_reading(sample_t s);
    tpq_pkg::tpq_result_t r;
    int                   total;
    total = 0;
    r.sample_taken = 1'b0;
    if (holdoff_left != 0) begin
      holdoff_left = holdoff_left - 1'b1;
    end else begin
      for (int i = 1; i < WINDOW_DEPTH; i++) avg_window[i-1] = avg_window[i];
      avg_window[WINDOW_DEPTH-1] = s;
      for (int i = 0; i < WINDOW_DEPTH; i++) total += avg_window[i];
      pos_before     = pos_now;
      pos_now        = mean_to_position(total / WINDOW_DEPTH);
      holdoff_left   = holdoff_setting;
      r.sample_taken = 1'b1;
    end
    r.position = pos_now;
    r.changed  = (holdoff_left == 0) && (pos_now != pos_before);
    return r;
  endfunction

  function automatic bit take_gap();
    return !steady && ($urandom_range(99) < IDLE_PCT);
  endfunction

  // ---------------------------------------------------------------------
  // Driver: presents backlog samples with random gaps. A stalled sample is
  // held unchanged; in_valid is decided without looking at in_stall.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : drive_samples
    logic    nxt_valid;
    sample_t nxt_sample;
    nxt_valid  = in_valid;
    nxt_sample = adc_sample;
    if (rst) begin
      nxt_valid = 1'b0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) pending_results.push_back(predict_reading(adc_sample));
      if (sample_backlog.size() != 0 && !take_gap()) begin
        nxt_sample = sample_backlog.pop_front();
        nxt_valid  = 1'b1;
      end else begin
        nxt_valid = 1'b0;
      end
    end
    in_valid   <= nxt_valid;
    adc_sample <= nxt_sample;
  end

  // ---------------------------------------------------------------------
  // Monitor: checks each result transaction against the oldest prediction,
  // and stalls the result side at random.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    tpq_pkg::tpq_result_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $error("result transaction with no prediction waiting: pos %0d", position);
          error_count++;
        end else begin
          want = pending_results.pop_front();
          if (position !== want.position) begin
            $error("position: expected %0d, got %0d", want.position, position);
            error_count++;
          end
          if (changed !== want.changed) begin
            $error("changed: expected %0b, got %0b", want.changed, changed);
            error_count++;
          end
          if (sample_taken !== want.sample_taken) begin
            $error("sample_taken: expected %0b, got %0b", want.sample_taken, sample_taken);
            error_count++;
          end
        end
      end
      out_stall <= take_gap();
    end
  end

  // Watchdog: any accepted transaction on any channel resets the count.
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_MAX) begin
      $display("throttle_pot_position_quantizer_top_test: done, errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------

  // Wait until the backlog is sent and every predicted result has arrived,
  // then let the pipeline go quiet. Checked on the
  // falling edge, where the driver's updates have settled.
  task automatic wait_drained();
    @(negedge clk);
    while (sample_backlog.size() != 0 || in_valid || pending_results.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Register write; only done with nothing in flight.
  task automatic write_holdoff(ticks_t ticks);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= ticks;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    holdoff_setting = ticks;
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Random samples in bursts. Bursts of one value long enough to fill the
  // window (given the hold-off spacing) put means within 2 of the step
  // boundaries and breakpoints; the rest is full-range noise and rail values.
  task automatic queue_samples(int count, ticks_t ticks);
    int          made;
    int          run;
    int          pick;
    int          val;
    int unsigned edges[9] = '{710, 627, 517, 407, 336, 768, 682, 352, 304};
    made = 0;
    while (made < count) begin
      pick = $urandom_range(99);
      if (pick < 50) begin
        val = int'(edges[$urandom_range(8)]) + $urandom_range(4) - 2;
        run = WINDOW_DEPTH * (ticks + 1);
      end else if (pick < 85) begin
        val = $urandom_range((1 << SAMPLE_BITS) - 1);
        run = $urandom_range(1, 6);
      end else begin
        val = ($urandom_range(1) != 0) ? (1 << SAMPLE_BITS) - 1 : 0;
        run = $urandom_range(1, WINDOW_DEPTH * (ticks + 1));
      end
      for (int i = 0; i < run && made < count; i++) begin
        sample_backlog.push_back(sample_t'(val));
        made++;
      end
    end
  endtask

  task automatic run_phase(ticks_t ticks, int count, bit no_gaps);
    write_holdoff(ticks);
    steady = no_gaps;
    queue_samples(count, ticks);
    wait_drained();
    steady = 1'b0;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset hold-off of 250: first sample is used, the rest are skipped.
    queue_samples(12, '0);

    // Directed with no hold-off: rails, curve breakpoints, step boundaries.
    write_holdoff('0);
    begin : directed
      sample_t list[24];
      list = '{10'd0, 10'd0, 10'd0, 10'd0, 10'd1023, 10'd1023, 10'd1023,
               10'd1023, 10'd768, 10'd769, 10'd682, 10'd352, 10'd304,
               10'd303, 10'd711, 10'd710, 10'd628, 10'd627, 10'd518,
               10'd517, 10'd408, 10'd407, 10'd337, 10'd336};
      foreach (list[i]) sample_backlog.push_back(list[i]);
    end
    wait_drained();

    // Random phases over several hold-off settings, extremes included.
    // The pause before each write is the sender waiting for every result.
    run_phase(8'd0,   500, 1'b0);
    run_phase(8'd255, 260, 1'b0);
    run_phase(8'd1,   200, 1'b1);   // long stretch with no idling at all
    run_phase(8'd3,   150, 1'b0);
    run_phase(ticks_t'($urandom_range(2, 7)), 100, 1'b0);
    run_phase(8'd0,   100, 1'b0);

    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("throttle_pot_position_quantizer_top_test: done, clean");
    end else begin
      $display("throttle_pot_position_quantizer_top_test: done, errors");
    end
    $finish;
  end

endmodule
